// File: hdl/kcl_pkg.sv
// shared constants, codes and types for the keypad code lock
package kcl_pkg;

    localparam int DIGITS  = 4;
    localparam int ENTRY_W = 14;
    localparam int CNT_W   = 4;
    localparam int KEY_W   = 4;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = ENTRY_W;

    // entry * 10 + digit stays below 2^(ENTRY_W + 4)
    localparam int PROD_W      = ENTRY_W + 4;
    localparam int ENTRY_LIMIT = 10 ** DIGITS;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    localparam logic [ENTRY_W-1:0] SECRET_RST   = ENTRY_W'(8051);
    localparam logic [CNT_W-1:0]   MAX_ATT_RST  = CNT_W'(3);
    localparam logic [CNT_W-1:0]   LOCKOUT_RST  = CNT_W'(5);
    localparam logic [CNT_W-1:0]   MESSAGE_RST  = CNT_W'(1);

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [KEY_W-1:0] KEY_ONE   = KEY_W'(1);
    localparam logic [KEY_W-1:0] KEY_ZERO  = KEY_W'(10);
    localparam logic [KEY_W-1:0] KEY_ENTER = KEY_W'(11);
    localparam logic [KEY_W-1:0] KEY_CLEAR = KEY_W'(12);

    localparam logic [IDX_W-1:0] REG_SECRET  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_MAX_ATT = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_LOCKOUT = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_MESSAGE = IDX_W'(3);

    typedef enum logic [1:0] {
        MODE_ENTRY  = 2'd0,
        MODE_ACCEPT = 2'd1,
        MODE_REJECT = 2'd2,
        MODE_LOCKED = 2'd3
    } mode_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] secret_code;
        logic [CNT_W-1:0]   max_attempts;
        logic [CNT_W-1:0]   lockout_seconds;
        logic [CNT_W-1:0]   message_seconds;
    } cfg_t;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key_code;
    } item_t;

    // first output field sits in the highest bits
    typedef struct packed {
        logic               unlock_pulse;
        logic [CNT_W-1:0]   attempts_left;
        logic [CNT_W-1:0]   lockout_remaining;
        logic [1:0]         status;
        logic [ENTRY_W-1:0] entry_value;
    } res_t;

    localparam int RES_W = $bits(res_t);

endpackage

// File: hdl/kcl_cfg.sv
// configuration register file of the keypad code lock
module kcl_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [kcl_pkg::IDX_W-1:0]    cfg_index,
    input  logic [kcl_pkg::CFG_W-1:0]    cfg_wdata,
    output kcl_pkg::cfg_t                cfg
);

    kcl_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.secret_code     <= kcl_pkg::SECRET_RST;
            cfg_reg.max_attempts    <= kcl_pkg::MAX_ATT_RST;
            cfg_reg.lockout_seconds <= kcl_pkg::LOCKOUT_RST;
            cfg_reg.message_seconds <= kcl_pkg::MESSAGE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                kcl_pkg::REG_SECRET:  cfg_reg.secret_code     <= cfg_wdata;
                kcl_pkg::REG_MAX_ATT: cfg_reg.max_attempts    <= cfg_wdata[kcl_pkg::CNT_W-1:0];
                kcl_pkg::REG_LOCKOUT: cfg_reg.lockout_seconds <= cfg_wdata[kcl_pkg::CNT_W-1:0];
                kcl_pkg::REG_MESSAGE: cfg_reg.message_seconds <= cfg_wdata[kcl_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/kcl_fsm.sv
// lock state registers and the single-pass update for one item
module kcl_fsm (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,
    input  kcl_pkg::item_t item,
    input  kcl_pkg::cfg_t  cfg,
    output kcl_pkg::res_t  res
);

    kcl_pkg::mode_t               mode_reg, mode_next;
    logic [kcl_pkg::ENTRY_W-1:0]  entry_reg, entry_next;
    logic [kcl_pkg::CNT_W-1:0]    attempts_reg, attempts_next;
    logic [kcl_pkg::CNT_W-1:0]    countdown_reg, countdown_next;
    logic                         unlock;
    logic [kcl_pkg::KEY_W-1:0]    digit;
    logic [kcl_pkg::PROD_W-1:0]   shifted;
    logic                         is_digit;

    assign is_digit = (item.key_code >= kcl_pkg::KEY_ONE) && (item.key_code <= kcl_pkg::KEY_ZERO);
    assign digit    = (item.key_code == kcl_pkg::KEY_ZERO) ? '0 : item.key_code;
    // entry * 10 as two shifts
    assign shifted  = {entry_reg, 3'b000} + {2'b00, entry_reg, 1'b0}
                    + kcl_pkg::PROD_W'(digit);

    always_comb begin
        mode_next      = mode_reg;
        entry_next     = entry_reg;
        attempts_next  = attempts_reg;
        countdown_next = countdown_reg;
        unlock         = 1'b0;
        if (step) begin
            if (item.command == kcl_pkg::CMD_TICK) begin
                if (mode_reg != kcl_pkg::MODE_ENTRY) begin
                    priority if (countdown_reg > kcl_pkg::CNT_W'(1)) begin
                        countdown_next = countdown_reg - kcl_pkg::CNT_W'(1);
                    end else if (mode_reg == kcl_pkg::MODE_REJECT && attempts_reg == '0) begin
                        mode_next      = kcl_pkg::MODE_LOCKED;
                        countdown_next = cfg.lockout_seconds;
                    end else begin
                        if (mode_reg == kcl_pkg::MODE_LOCKED) begin
                            attempts_next = cfg.max_attempts;
                        end
                        mode_next      = kcl_pkg::MODE_ENTRY;
                        countdown_next = '0;
                    end
                end
            end else if (mode_reg == kcl_pkg::MODE_ENTRY) begin
                priority if (is_digit) begin
                    entry_next = (shifted >= kcl_pkg::PROD_W'(kcl_pkg::ENTRY_LIMIT))
                               ? '0 : shifted[kcl_pkg::ENTRY_W-1:0];
                end else if (item.key_code == kcl_pkg::KEY_ENTER) begin
                    if (entry_reg == cfg.secret_code) begin
                        unlock    = 1'b1;
                        mode_next = kcl_pkg::MODE_ACCEPT;
                    end else begin
                        if (attempts_reg != '0) begin
                            attempts_next = attempts_reg - kcl_pkg::CNT_W'(1);
                        end
                        mode_next = kcl_pkg::MODE_REJECT;
                    end
                    countdown_next = cfg.message_seconds;
                    entry_next     = '0;
                end else if (item.key_code == kcl_pkg::KEY_CLEAR) begin
                    entry_next = '0;
                end else begin
                    entry_next = entry_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= kcl_pkg::MODE_ENTRY;
            entry_reg     <= '0;
            attempts_reg  <= kcl_pkg::MAX_ATT_RST;
            countdown_reg <= '0;
        end else begin
            mode_reg      <= mode_next;
            entry_reg     <= entry_next;
            attempts_reg  <= attempts_next;
            countdown_reg <= countdown_next;
        end
    end

    // result reflects the state after this item
    assign res.entry_value       = entry_next;
    assign res.status            = mode_next;
    assign res.lockout_remaining = (mode_next == kcl_pkg::MODE_LOCKED) ? countdown_next : '0;
    assign res.attempts_left     = attempts_next;
    assign res.unlock_pulse      = unlock;

    a_entry_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == kcl_pkg::MODE_ENTRY |-> countdown_reg == '0)
        else $error("countdown running in entry mode");

    a_unlock_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        unlock |-> mode_next == kcl_pkg::MODE_ACCEPT && entry_reg == cfg.secret_code)
        else $error("unlock without accepted code");

    a_busy_keys: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.command == kcl_pkg::CMD_KEY && mode_reg != kcl_pkg::MODE_ENTRY
        |=> $stable(entry_reg) && $stable(mode_reg) && $stable(attempts_reg))
        else $error("key changed state while busy");

    a_tick_count: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.command == kcl_pkg::CMD_TICK && mode_reg != kcl_pkg::MODE_ENTRY
        && countdown_reg > kcl_pkg::CNT_W'(1)
        |=> countdown_reg == $past(countdown_reg) - kcl_pkg::CNT_W'(1))
        else $error("countdown did not step down on tick");

endmodule

// File: hdl/keypad_code_lock_core.sv
// top level of the keypad code lock: input register, update, result register
//
// One result transfer per input transfer. A transfer is taken into the input
// register, its update runs through the lock state logic and lands in the
// result register, and a new item is taken in every cycle while the result
// side keeps up. Keys are digits 1..10 (10 is zero), 11 enter and 12 clear;
// ticks count down the message and lockout. Configuration writes apply at
// once and should be made while idle.
module keypad_code_lock_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kcl_pkg::S_TDATA_W-1:0]   s_tdata,   // key_code[3:0]
    input  logic                            s_tuser,   // command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // entry_value[13:0], status[15:14], lockout_remaining[19:16],
    // attempts_left[23:20], unlock_pulse[24]
    output logic [kcl_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_we,
    input  logic [kcl_pkg::IDX_W-1:0]       cfg_index,
    input  logic [kcl_pkg::CFG_W-1:0]       cfg_wdata
);

    kcl_pkg::cfg_t  cfg;
    kcl_pkg::item_t in_item_reg;
    kcl_pkg::res_t  res;
    kcl_pkg::res_t  out_res_reg;
    logic           in_valid_reg;
    logic           out_valid_reg;
    logic           advance;
    logic           s_xfer;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    kcl_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    kcl_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg.command  <= s_tuser;
            in_item_reg.key_code <= s_tdata[kcl_pkg::KEY_W-1:0];
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(kcl_pkg::M_TDATA_W - kcl_pkg::RES_W){1'b0}}, out_res_reg};

endmodule
